/* rtl/ttx_pkg.sv */
`timescale 1ns / 1ps

package ttx_pkg;

    // Widest header the block supports and the byte index width that covers it.
    localparam int MAX_HEADER_LENGTH = 32;
    localparam int POS_W             = 5;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_NONE  = 8'hFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_MAX_MISMATCH = 2'd0;
    localparam logic [1:0] REG_MIN_REPEATS  = 2'd1;
    localparam logic [1:0] REG_MIN_BIT_ERR  = 2'd2;

    localparam logic [3:0] MAX_MISMATCH_RST = 4'd10;
    localparam logic [1:0] MIN_REPEATS_RST  = 2'd3;
    localparam logic [6:0] MIN_BIT_ERR_RST  = 7'd8;

    localparam int QUEUE_DEPTH  = 2;
    localparam int RESULT_DEPTH = 2;

    typedef struct packed {
        logic [3:0] max_mismatch;
        logic [1:0] min_repeats;
        logic [6:0] min_bit_errors;
    } cfg_t;

    typedef struct packed {
        logic             restart;
        logic             decimal;
        logic             parity_ok;
        logic             last;
        logic [POS_W-1:0] idx;
        logic [6:0]       dec;
        logic [7:0]       c0;
        logic [7:0]       c1;
        logic [7:0]       c2;
    } entry_t;

    typedef struct packed {
        logic       locked;
        logic       output_enable;
        logic       source_ok;
        logic [3:0] number_position;
        logic [3:0] mismatch_count;
    } result_t;

    function automatic logic [7:0] hex_char(input logic [3:0] d);
        if (d < 4'd10)
        begin
            return 8'h30 + {4'h0, d};
        end
        return 8'h37 + {4'h0, d};
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] v);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 8; i++)
        begin
            n = n + {3'b000, v[i]};
        end
        return n;
    endfunction

endpackage

/* rtl/ttx_fifo.sv */
`timescale 1ns / 1ps

module ttx_fifo
    import ttx_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             full,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg;
    logic [AW-1:0]    wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg;
    logic [AW-1:0]    rd_ptr_next;
    logic [AW:0]      count_reg;
    logic [AW:0]      count_next;
    logic             do_wr;
    logic             do_rd;

    assign full    = (count_reg == (AW+1)'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

/* rtl/ttx_front.sv */
`timescale 1ns / 1ps

module ttx_front
    import ttx_pkg::*;
#(
    parameter int HEADER_LENGTH = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  logic        queue_full,
    input  logic        action,
    input  logic [7:0]  header_byte,
    input  logic [11:0] page_number,
    output logic        queue_wr,
    output entry_t      entry
);

    logic [POS_W-1:0] byte_pos_reg;
    logic [POS_W-1:0] byte_pos_next;
    logic             last_byte;
    logic [11:0]      pn_adj;

    assign queue_wr  = push && !queue_full;
    assign last_byte = (byte_pos_reg == POS_W'(HEADER_LENGTH - 1));
    assign pn_adj    = (page_number < 12'h100) ? page_number + 12'h800 : page_number;

    always_comb
    begin
        entry.restart   = action;
        entry.decimal   = (page_number[3:0] <= 4'd9) && (page_number[7:4] <= 4'd9);
        entry.parity_ok = ^header_byte;
        entry.last      = !action && last_byte;
        entry.idx       = byte_pos_reg;
        entry.dec       = header_byte[6:0];
        entry.c0        = hex_char(pn_adj[11:8]);
        entry.c1        = hex_char(pn_adj[7:4]);
        entry.c2        = hex_char(pn_adj[3:0]);
    end

    always_comb
    begin
        byte_pos_next = byte_pos_reg;
        if (queue_wr)
        begin
            if (action || last_byte)
            begin
                byte_pos_next = '0;
            end
            else
            begin
                byte_pos_next = byte_pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_pos_reg <= '0;
        end
        else
        begin
            byte_pos_reg <= byte_pos_next;
        end
    end

endmodule

/* rtl/ttx_back.sv */
`timescale 1ns / 1ps

module ttx_back
    import ttx_pkg::*;
#(
    parameter int HEADER_LENGTH = 17
) (
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  entry_t  ent,
    input  logic    queue_empty,
    output logic    queue_rd,
    input  logic    result_full,
    output logic    result_wr,
    output result_t result
);

    localparam int IW = $clog2(HEADER_LENGTH);
    localparam int SW = HEADER_LENGTH - 2;
    localparam logic [5:0] CMP_MIN    = 6'(HEADER_LENGTH / 2);
    localparam logic [5:0] BLANK_MAX  = 6'(HEADER_LENGTH * 2 / 3);
    localparam logic [5:0] PARERR_MAX = 6'(HEADER_LENGTH / 4);

    logic [7:0]    ref_reg [HEADER_LENGTH];
    logic [7:0]    cur_reg [HEADER_LENGTH];
    logic [1:0]    rep_reg [HEADER_LENGTH];
    logic [7:0]    ref_n   [HEADER_LENGTH];
    logic          lock_reg;
    logic          lock_next;
    logic [3:0]    mm_reg;
    logic [3:0]    mm_next;
    logic [IW-1:0] dp_reg;
    logic [IW-1:0] dp_next;
    logic          found_reg;
    logic          found_next;
    logic [6:0]    bds_reg;
    logic [4:0]    blank_reg;
    logic [4:0]    par_reg;
    logic [4:0]    sdiff_reg;
    logic [4:0]    stab_reg;
    logic [6:0]    bds_n;
    logic [4:0]    blank_n;
    logic [4:0]    par_n;
    logic [4:0]    sdiff_n;
    logic [4:0]    stab_n;

    logic          step;
    logic [IW-1:0] iw;
    logic [7:0]    dec8;
    logic [7:0]    ref_b;
    logic [7:0]    cur_b;
    logic [1:0]    rep_b;
    logic [7:0]    ref_w;
    logic [7:0]    cur_w;
    logic [1:0]    rep_w;
    logic          skip;
    logic [3:0]    bds_inc;
    logic          blank_inc;
    logic          par_inc;
    logic          sdiff_inc;
    logic          stab_inc;
    logic [7:0]    bds_sum;
    logic [5:0]    blank_sum;
    logic [5:0]    par_sum;
    logic [5:0]    sdiff_sum;
    logic [5:0]    stab_sum;
    logic [SW-1:0] match;
    logic [IW-1:0] srch_pos;
    logic          srch_found;
    logic          relock;

    assign step      = !queue_empty && !result_full;
    assign queue_rd  = step;
    assign result_wr = step && ent.last;

    assign iw    = ent.idx[IW-1:0];
    assign dec8  = {1'b0, ent.dec};
    assign ref_b = ref_reg[iw];
    assign cur_b = cur_reg[iw];
    assign rep_b = rep_reg[iw];
    assign skip  = found_reg && ({1'b0, iw} >= {1'b0, dp_reg})
                   && ({1'b0, iw} <= {1'b0, dp_reg} + (IW+1)'(2));

    always_comb
    begin
        ref_w     = ref_b;
        cur_w     = cur_b;
        rep_w     = rep_b;
        bds_inc   = 4'd0;
        blank_inc = 1'b0;
        par_inc   = 1'b0;
        sdiff_inc = 1'b0;
        stab_inc  = 1'b0;
        if (ent.decimal)
        begin
            if (lock_reg)
            begin
                if (!skip)
                begin
                    if (ent.parity_ok)
                    begin
                        if (dec8 != ref_b)
                        begin
                            bds_inc = popcount8(dec8 ^ ref_b);
                        end
                        blank_inc = (dec8 == CHAR_SPACE);
                        if (dec8 != cur_b)
                        begin
                            cur_w = dec8;
                            rep_w = 2'd1;
                        end
                        else if (rep_b < cfg.min_repeats)
                        begin
                            rep_w = rep_b + 2'd1;
                        end
                    end
                    else if (ref_b != CHAR_NONE)
                    begin
                        par_inc = 1'b1;
                    end
                    sdiff_inc = (rep_w >= cfg.min_repeats) && (cur_w != ref_b);
                end
            end
            else
            begin
                if (ent.parity_ok)
                begin
                    if ((rep_b == 2'd0) || (dec8 != ref_b))
                    begin
                        ref_w = dec8;
                        rep_w = 2'd1;
                    end
                    else if (rep_b < cfg.min_repeats)
                    begin
                        rep_w = rep_b + 2'd1;
                    end
                end
                stab_inc = (rep_w >= cfg.min_repeats);
            end
        end
    end

    always_comb
    begin
        bds_sum   = {1'b0, bds_reg} + {4'h0, bds_inc};
        blank_sum = {1'b0, blank_reg} + {5'h00, blank_inc};
        par_sum   = {1'b0, par_reg} + {5'h00, par_inc};
        sdiff_sum = {1'b0, sdiff_reg} + {5'h00, sdiff_inc};
        stab_sum  = {1'b0, stab_reg} + {5'h00, stab_inc};
        bds_n     = bds_sum[7] ? 7'd127 : bds_sum[6:0];
        blank_n   = blank_sum[5] ? 5'd31 : blank_sum[4:0];
        par_n     = par_sum[5] ? 5'd31 : par_sum[4:0];
        sdiff_n   = sdiff_sum[5] ? 5'd31 : sdiff_sum[4:0];
        stab_n    = stab_sum[5] ? 5'd31 : stab_sum[4:0];
    end

    // Digit search over the reference as it stands after this byte.
    always_comb
    begin
        for (int i = 0; i < HEADER_LENGTH; i++)
        begin
            ref_n[i] = (IW'(i) == iw) ? ref_w : ref_reg[i];
        end
        for (int i = 0; i < SW; i++)
        begin
            match[i] = (ref_n[i] == ent.c0) && (ref_n[i+1] == ent.c1)
                       && (ref_n[i+2] == ent.c2);
        end
        srch_pos   = '0;
        srch_found = 1'b0;
        for (int i = SW - 1; i >= 0; i--)
        begin
            if (match[i])
            begin
                srch_pos   = IW'(i);
                srch_found = 1'b1;
            end
        end
    end

    always_comb
    begin
        lock_next  = lock_reg;
        mm_next    = mm_reg;
        dp_next    = dp_reg;
        found_next = found_reg;
        relock     = 1'b0;
        if (ent.last && ent.decimal)
        begin
            if (lock_reg)
            begin
                if (sdiff_n != 5'd0)
                begin
                    mm_next   = cfg.max_mismatch;
                    lock_next = 1'b0;
                end
                else if (({1'b0, par_n} <= PARERR_MAX)
                         && (({1'b0, blank_n} + {1'b0, par_n}) <= BLANK_MAX)
                         && (bds_n >= cfg.min_bit_errors))
                begin
                    mm_next = (mm_reg == 4'hF) ? 4'hF : mm_reg + 4'd1;
                    if (mm_next >= cfg.max_mismatch)
                    begin
                        lock_next = 1'b0;
                    end
                end
                else
                begin
                    mm_next = 4'd0;
                end
            end
            else if ({1'b0, stab_n} >= CMP_MIN)
            begin
                dp_next    = srch_pos;
                found_next = srch_found;
                if (srch_found)
                begin
                    relock    = 1'b1;
                    mm_next   = 4'd0;
                    lock_next = 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        result.locked          = lock_next;
        result.output_enable   = (mm_next == 4'd0);
        result.source_ok       = (mm_next < cfg.max_mismatch);
        result.number_position = found_next ? 4'(dp_next) : 4'hF;
        result.mismatch_count  = mm_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < HEADER_LENGTH; i++)
            begin
                ref_reg[i] <= CHAR_NONE;
                cur_reg[i] <= 8'h00;
                rep_reg[i] <= 2'd0;
            end
            lock_reg  <= 1'b0;
            mm_reg    <= 4'd0;
            dp_reg    <= '0;
            found_reg <= 1'b1;
            bds_reg   <= '0;
            blank_reg <= '0;
            par_reg   <= '0;
            sdiff_reg <= '0;
            stab_reg  <= '0;
        end
        else if (step)
        begin
            if (ent.restart)
            begin
                for (int i = 0; i < HEADER_LENGTH; i++)
                begin
                    ref_reg[i] <= CHAR_NONE;
                    rep_reg[i] <= 2'd0;
                end
                lock_reg  <= 1'b0;
                bds_reg   <= '0;
                blank_reg <= '0;
                par_reg   <= '0;
                sdiff_reg <= '0;
                stab_reg  <= '0;
            end
            else
            begin
                ref_reg[iw] <= ref_w;
                if (relock)
                begin
                    for (int i = 0; i < HEADER_LENGTH; i++)
                    begin
                        rep_reg[i] <= 2'd1;
                        cur_reg[i] <= ref_n[i];
                    end
                end
                else
                begin
                    cur_reg[iw] <= cur_w;
                    rep_reg[iw] <= rep_w;
                end
                lock_reg  <= lock_next;
                mm_reg    <= mm_next;
                dp_reg    <= dp_next;
                found_reg <= found_next;
                if (ent.last)
                begin
                    bds_reg   <= '0;
                    blank_reg <= '0;
                    par_reg   <= '0;
                    sdiff_reg <= '0;
                    stab_reg  <= '0;
                end
                else
                begin
                    bds_reg   <= bds_n;
                    blank_reg <= blank_n;
                    par_reg   <= par_n;
                    sdiff_reg <= sdiff_n;
                    stab_reg  <= stab_n;
                end
            end
        end
    end

    a_restart_unlocks: assert property (@(posedge clk) disable iff (!rst_n)
        step && ent.restart |=> !lock_reg)
        else $error("lock survived a restart");

    a_lock_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
        lock_reg |-> found_reg)
        else $error("locked without page number digits");

    a_lock_at_header_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(lock_reg) |-> $past(step && ent.last))
        else $error("lock rose outside the end of a header");

    a_result_room: assert property (@(posedge clk) disable iff (!rst_n)
        result_wr |-> !result_full && !queue_empty)
        else $error("result written without room");

endmodule

/* rtl/teletext_header_lock_tracker_top.sv */
`timescale 1ns / 1ps

// Teletext header lock tracker.
// Input queue: present one header byte (action 0) or a restart (action 1) with
// the page number of its header; the item is taken at an edge with push high
// and full low. HEADER_LENGTH bytes make one header.
// Result queue: after the last byte of each header one result waits on the
// result ports while empty is low; it is taken at an edge with pop high.
// Bytes other than the last, and restarts, give no result.
// Throughput is one item per cycle while the result queue has room; a classifier
// in front feeds a two-entry queue, and the tracker behind it retires one item
// per cycle. The tracker's result for a header's last byte is registered into
// the result queue and shown on its ports. When pop is held low the two-entry
// result queue fills, the tracker stops, the input queue fills and full rises.
// Reset clears the reference header, repeat counts, lock and counters at once;
// no clearing pass follows. Registers on the APB port sit at byte addresses 0,
// 4 and 8, to be written by the user only while idle; the block does not check.
module teletext_header_lock_tracker_top
    import ttx_pkg::*;
#(
    parameter int HEADER_LENGTH = 17
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic        action,
    input  logic [7:0]  header_byte,
    input  logic [11:0] page_number,
    output logic        empty,
    input  logic        pop,
    output logic        locked,
    output logic        output_enable,
    output logic        source_ok,
    output logic [3:0]  number_position,
    output logic [3:0]  mismatch_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    logic    cfg_wr;
    entry_t  front_entry;
    entry_t  back_entry;
    logic    front_wr;
    logic    queue_full;
    logic    queue_empty;
    logic    queue_rd;
    logic    result_wr;
    logic    result_full;
    result_t back_result;
    result_t head_result;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_MAX_MISMATCH: cfg_next.max_mismatch   = pwdata[3:0];
                REG_MIN_REPEATS:  cfg_next.min_repeats    = pwdata[1:0];
                REG_MIN_BIT_ERR:  cfg_next.min_bit_errors = pwdata[6:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_MAX_MISMATCH: prdata = {28'h0, cfg_reg.max_mismatch};
            REG_MIN_REPEATS:  prdata = {30'h0, cfg_reg.min_repeats};
            REG_MIN_BIT_ERR:  prdata = {25'h0, cfg_reg.min_bit_errors};
            default:          prdata = 32'h0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.max_mismatch   <= MAX_MISMATCH_RST;
            cfg_reg.min_repeats    <= MIN_REPEATS_RST;
            cfg_reg.min_bit_errors <= MIN_BIT_ERR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign full = queue_full;

    ttx_front #(
        .HEADER_LENGTH (HEADER_LENGTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .queue_full  (queue_full),
        .action      (action),
        .header_byte (header_byte),
        .page_number (page_number),
        .queue_wr    (front_wr),
        .entry       (front_entry)
    );

    ttx_fifo #(
        .WIDTH ($bits(entry_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_wr),
        .wr_data (front_entry),
        .rd_en   (queue_rd),
        .rd_data (back_entry),
        .full    (queue_full),
        .empty   (queue_empty)
    );

    ttx_back #(
        .HEADER_LENGTH (HEADER_LENGTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .ent         (back_entry),
        .queue_empty (queue_empty),
        .queue_rd    (queue_rd),
        .result_full (result_full),
        .result_wr   (result_wr),
        .result      (back_result)
    );

    ttx_fifo #(
        .WIDTH ($bits(result_t)),
        .DEPTH (RESULT_DEPTH)
    ) u_result (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (result_wr),
        .wr_data (back_result),
        .rd_en   (pop),
        .rd_data (head_result),
        .full    (result_full),
        .empty   (empty)
    );

    assign locked          = head_result.locked;
    assign output_enable   = head_result.output_enable;
    assign source_ok       = head_result.source_ok;
    assign number_position = head_result.number_position;
    assign mismatch_count  = head_result.mismatch_count;

endmodule
